[rtl/lance_csr_pkg.sv]
// ----------------------------------------------------------------------------
// lance_csr_pkg
// Shared types and constants of the LANCE register block: bus request codes,
// CSR0 bit positions and masks, register indexes and the CSR0 update record.
// ----------------------------------------------------------------------------
package lance_csr_pkg;

    // Bus request codes.
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_SET   = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    // Port select codes.
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_RAP  = 1'b1;

    // Widths fixed by the bus and the register layout.
    localparam int DATA_W      = 16;
    localparam int PTR_W       = 7;
    localparam int INIT_ADDR_W = 15;
    localparam int CSR2_W      = 8;
    localparam int CSR3_W      = 3;

    // CSR0 bit positions.
    localparam int BIT_ERR  = 15;
    localparam int BIT_BABL = 14;
    localparam int BIT_CERR = 13;
    localparam int BIT_MISS = 12;
    localparam int BIT_MERR = 11;
    localparam int BIT_RINT = 10;
    localparam int BIT_TINT = 9;
    localparam int BIT_IDON = 8;
    localparam int BIT_INTR = 7;
    localparam int BIT_INEA = 6;
    localparam int BIT_RXON = 5;
    localparam int BIT_TXON = 4;
    localparam int BIT_TDMD = 3;
    localparam int BIT_STOP = 2;
    localparam int BIT_STRT = 1;
    localparam int BIT_INIT = 0;

    // CSR0 bit groups.
    localparam logic [15:0] M_INEA = 16'h0040;
    localparam logic [15:0] M_STOP = 16'h0004;
    localparam logic [15:0] M_CMD  = 16'h000f;   // INIT, STRT, STOP, TDMD
    localparam logic [15:0] M_W1C  = 16'h7f00;   // IDON through BABL
    localparam logic [15:0] M_SRC  = 16'h5f00;   // interrupt sources
    localparam logic [15:0] M_ERRS = 16'h7800;   // BABL, CERR, MISS, MERR

    // Mode bits kept by the block.
    localparam int MODE_W  = 2;
    localparam int MODE_DRX = 0;
    localparam int MODE_DTX = 1;

    // Register masks on write.
    localparam logic [15:0] CSR1_MASK = 16'hfffe;

    // Reset values.
    localparam logic [15:0] CSR0_RESET = 16'h0004;
    localparam logic [15:0] CSR4_RESET = 16'h0115;

    // Fixed chip ID words.
    localparam logic [15:0] CHIP_ID_LO = 16'(1 << (28 - 16));
    localparam logic [15:0] CHIP_ID_HI = 16'h3003;

    // Register indexes.
    localparam logic [6:0] IDX_CSR0       = 7'd0;
    localparam logic [6:0] IDX_CSR1       = 7'd1;
    localparam logic [6:0] IDX_CSR2       = 7'd2;
    localparam logic [6:0] IDX_CSR3       = 7'd3;
    localparam logic [6:0] IDX_CSR4       = 7'd4;
    localparam logic [6:0] IDX_LADRF0     = 7'd8;
    localparam logic [6:0] IDX_LADRF1     = 7'd9;
    localparam logic [6:0] IDX_LADRF2     = 7'd10;
    localparam logic [6:0] IDX_LADRF3     = 7'd11;
    localparam logic [6:0] IDX_PADR0      = 7'd12;
    localparam logic [6:0] IDX_PADR1      = 7'd13;
    localparam logic [6:0] IDX_PADR2      = 7'd14;
    localparam logic [6:0] IDX_MODE       = 7'd15;
    localparam logic [6:0] IDX_RX_BASE_LO = 7'd24;
    localparam logic [6:0] IDX_RX_BASE_HI = 7'd25;
    localparam logic [6:0] IDX_TX_BASE_LO = 7'd30;
    localparam logic [6:0] IDX_TX_BASE_HI = 7'd31;
    localparam logic [6:0] IDX_RX_LEN     = 7'd76;
    localparam logic [6:0] IDX_TX_LEN     = 7'd78;
    localparam logic [6:0] IDX_CHIP_LO    = 7'd88;
    localparam logic [6:0] IDX_CHIP_HI    = 7'd89;

    // Outcome of one CSR0 update.
    typedef struct packed {
        logic [15:0] csr0;
        logic        csr3_clear;
        logic        init_flag;
        logic        init_now;
        logic        tx_demand;
        logic        irq;
    } csr0_upd_t;

endpackage

[rtl/lance_csr_register_block_unit.sv]
// ----------------------------------------------------------------------------
// lance_csr_register_block_unit
// LANCE register file: address pointer, data port, CSR0 control logic and a
// general register store, serving one bus request per cycle while results are taken.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  request   in_valid / in_ready     action, port_select, write_data
//  result    out_valid / out_ready   read_data, irq_pulse, tx_demand_pulse,
//                                    init_request, init_address
//
//  One request per cycle sustained while results are taken; a result passes
//  through the input register, then the result register.
//  The store read is prefetched at the next pointer value, so a read right
//  after a pointer write finds its entry already read out.
//  Reset clears the pointer, CSR0 to STOP, CSR1..CSR3 and the store valid
//  bits at once; no clearing pass is needed.
//  A stalled result holds the result register while one more request waits
//  in the input register.
// ----------------------------------------------------------------------------
module lance_csr_register_block_unit #(
    parameter int REG_COUNT       = 128,
    parameter int BOARD_ADDR_BITS = 15
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            action,
    input  logic                                  port_select,
    input  logic [lance_csr_pkg::DATA_W-1:0]      write_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lance_csr_pkg::DATA_W-1:0]      read_data,
    output logic                                  irq_pulse,
    output logic                                  tx_demand_pulse,
    output logic                                  init_request,
    output logic [lance_csr_pkg::INIT_ADDR_W-1:0] init_address
);

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam logic [lance_csr_pkg::PTR_W:0] REG_LIMIT = (lance_csr_pkg::PTR_W + 1)'(REG_COUNT);
    localparam logic [24:0] ADDR_MASK = (25'd1 << BOARD_ADDR_BITS) - 25'd1;

    // Input register.
    logic                               item_valid_reg;
    lance_csr_pkg::action_t             item_action_reg;
    logic                               item_port_reg;
    logic [lance_csr_pkg::DATA_W-1:0]   item_data_reg;

    // Architectural state.
    logic [lance_csr_pkg::PTR_W-1:0]    ptr_reg, ptr_next;
    logic [15:0]                        csr0_reg, csr0_next;
    logic [15:0]                        csr1_reg, csr1_next;
    logic [lance_csr_pkg::CSR2_W-1:0]   csr2_reg, csr2_next;
    logic [lance_csr_pkg::CSR3_W-1:0]   csr3_reg, csr3_next;
    logic [lance_csr_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic                               init_flag_reg, init_flag_next;

    // Result register.
    logic                               out_valid_reg;
    logic [lance_csr_pkg::DATA_W-1:0]   read_data_reg, read_data_next;
    logic                               irq_reg, irq_next;
    logic                               tx_reg, tx_next;
    logic                               init_req_reg, init_req_next;
    logic [lance_csr_pkg::INIT_ADDR_W-1:0] init_addr_reg, init_addr_next;

    logic                               exec_fire;
    logic                               ptr_in_range;
    logic                               csr0_op;
    logic                               store_we;
    logic [IDX_W-1:0]                   store_ra;
    logic [lance_csr_pkg::DATA_W-1:0]   store_rd;
    logic [23:0]                        init_block_addr;
    lance_csr_pkg::csr0_upd_t           upd;

    // Handshake: the request in the input register executes when the result slot frees.
    assign exec_fire = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || exec_fire;

    assign ptr_in_range    = {1'b0, ptr_reg} < REG_LIMIT;
    assign init_block_addr = {csr2_reg, csr1_reg};

    // CSR0 update logic.
    lance_csr_ctl u_ctl (
        .action     (item_action_reg),
        .write_data (item_data_reg),
        .csr0       (csr0_reg),
        .mode       (mode_reg),
        .init_flag  (init_flag_reg),
        .upd        (upd)
    );

    // General register store, read at the pointer of the next request.
    assign store_ra = ({1'b0, ptr_next} < REG_LIMIT) ? ptr_next[IDX_W-1:0] : '0;

    lance_csr_store #(
        .REG_COUNT (REG_COUNT)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (store_we),
        .wa    (ptr_reg[IDX_W-1:0]),
        .wd    (item_data_reg),
        .ra    (store_ra),
        .rd    (store_rd)
    );

    // Execution of one request.
    always_comb
    begin
        ptr_next       = ptr_reg;
        csr0_next      = csr0_reg;
        csr1_next      = csr1_reg;
        csr2_next      = csr2_reg;
        csr3_next      = csr3_reg;
        mode_next      = mode_reg;
        init_flag_next = init_flag_reg;
        store_we       = 1'b0;
        read_data_next = '0;
        irq_next       = 1'b0;
        tx_next        = 1'b0;
        init_req_next  = 1'b0;
        init_addr_next = '0;

        csr0_op = (item_action_reg == lance_csr_pkg::ACT_SET) ||
                  (item_action_reg == lance_csr_pkg::ACT_CLEAR) ||
                  ((item_action_reg == lance_csr_pkg::ACT_WRITE) &&
                   (item_port_reg == lance_csr_pkg::PORT_DATA) &&
                   (ptr_reg == lance_csr_pkg::IDX_CSR0));

        // Read data path.
        if (item_port_reg == lance_csr_pkg::PORT_RAP)
        begin
            read_data_next = {{(lance_csr_pkg::DATA_W - lance_csr_pkg::PTR_W){1'b0}}, ptr_reg};
        end
        else if (ptr_in_range)
        begin
            case (ptr_reg)
                lance_csr_pkg::IDX_CSR0:
                begin
                    read_data_next = csr0_reg;
                    if (|(csr0_reg & lance_csr_pkg::M_ERRS))
                    begin
                        read_data_next[lance_csr_pkg::BIT_ERR] = 1'b1;
                    end
                end
                lance_csr_pkg::IDX_CSR1:    read_data_next = csr1_reg;
                lance_csr_pkg::IDX_CSR2:    read_data_next = 16'(csr2_reg);
                lance_csr_pkg::IDX_CSR3:    read_data_next = 16'(csr3_reg);
                lance_csr_pkg::IDX_CHIP_LO: read_data_next = lance_csr_pkg::CHIP_ID_LO;
                lance_csr_pkg::IDX_CHIP_HI: read_data_next = lance_csr_pkg::CHIP_ID_HI;
                default:                    read_data_next = store_rd;
            endcase
        end
        if (item_action_reg != lance_csr_pkg::ACT_READ)
        begin
            read_data_next = '0;
        end

        if (exec_fire)
        begin
            if (csr0_op)
            begin
                // CSR0 write, set or clear.
                csr0_next      = upd.csr0;
                init_flag_next = upd.init_flag;
                irq_next       = upd.irq;
                tx_next        = upd.tx_demand;
                init_req_next  = upd.init_now;
                if (upd.csr3_clear)
                begin
                    csr3_next = '0;
                end
                if (upd.init_now)
                begin
                    init_addr_next = init_block_addr[lance_csr_pkg::INIT_ADDR_W-1:0] &
                                     ADDR_MASK[lance_csr_pkg::INIT_ADDR_W-1:0];
                end
            end
            else if ((item_action_reg == lance_csr_pkg::ACT_WRITE) &&
                     (item_port_reg == lance_csr_pkg::PORT_RAP))
            begin
                ptr_next = item_data_reg[lance_csr_pkg::PTR_W-1:0];
            end
            else if ((item_action_reg == lance_csr_pkg::ACT_WRITE) && ptr_in_range)
            begin
                // Data port write to a register other than CSR0.
                case (ptr_reg)
                    lance_csr_pkg::IDX_CSR1:
                    begin
                        if (csr0_reg[lance_csr_pkg::BIT_STOP])
                        begin
                            csr1_next = item_data_reg & lance_csr_pkg::CSR1_MASK;
                        end
                    end
                    lance_csr_pkg::IDX_CSR2:
                    begin
                        if (csr0_reg[lance_csr_pkg::BIT_STOP])
                        begin
                            csr2_next = item_data_reg[lance_csr_pkg::CSR2_W-1:0];
                        end
                    end
                    lance_csr_pkg::IDX_CSR3:
                    begin
                        if (csr0_reg[lance_csr_pkg::BIT_STOP])
                        begin
                            csr3_next = item_data_reg[lance_csr_pkg::CSR3_W-1:0];
                        end
                    end
                    lance_csr_pkg::IDX_MODE:
                    begin
                        mode_next = item_data_reg[lance_csr_pkg::MODE_W-1:0];
                    end
                    lance_csr_pkg::IDX_LADRF0, lance_csr_pkg::IDX_LADRF1,
                    lance_csr_pkg::IDX_LADRF2, lance_csr_pkg::IDX_LADRF3,
                    lance_csr_pkg::IDX_PADR0, lance_csr_pkg::IDX_PADR1,
                    lance_csr_pkg::IDX_PADR2,
                    lance_csr_pkg::IDX_RX_BASE_LO, lance_csr_pkg::IDX_RX_BASE_HI,
                    lance_csr_pkg::IDX_TX_BASE_LO, lance_csr_pkg::IDX_TX_BASE_HI,
                    lance_csr_pkg::IDX_RX_LEN, lance_csr_pkg::IDX_TX_LEN:
                    begin
                        // Writes to these registers are dropped; the store keeps its entry.
                        store_we = 1'b0;
                    end
                    default:
                    begin
                        store_we = 1'b1;
                    end
                endcase
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_action_reg <= lance_csr_pkg::action_t'(action);
            item_port_reg   <= port_select;
            item_data_reg   <= write_data;
        end
    end

    // Register state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            csr0_reg      <= lance_csr_pkg::CSR0_RESET;
            csr1_reg      <= '0;
            csr2_reg      <= '0;
            csr3_reg      <= '0;
            mode_reg      <= '0;
            init_flag_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            csr0_reg      <= csr0_next;
            csr1_reg      <= csr1_next;
            csr2_reg      <= csr2_next;
            csr3_reg      <= csr3_next;
            mode_reg      <= mode_next;
            init_flag_reg <= init_flag_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
            tx_reg        <= tx_next;
            init_req_reg  <= init_req_next;
            init_addr_reg <= init_addr_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = read_data_reg;
    assign irq_pulse       = irq_reg;
    assign tx_demand_pulse = tx_reg;
    assign init_request    = init_req_reg;
    assign init_address    = init_addr_reg;

    // Checks.
    a_init_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !init_req_reg |-> init_addr_reg == '0)
        else $error("init address set without an init request");

    a_ptr_write: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (item_action_reg == lance_csr_pkg::ACT_WRITE) &&
        (item_port_reg == lance_csr_pkg::PORT_RAP)
        |=> ptr_reg == $past(item_data_reg[lance_csr_pkg::PTR_W-1:0]))
        else $error("pointer write lost");

    a_intr_summary: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && csr0_op
        |=> csr0_reg[lance_csr_pkg::BIT_INTR] == |(csr0_reg & lance_csr_pkg::M_SRC))
        else $error("interrupt summary out of step with its sources");

    a_irq_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && irq_reg
        |-> csr0_reg[lance_csr_pkg::BIT_INTR] && csr0_reg[lance_csr_pkg::BIT_INEA])
        else $error("interrupt pulse without INTR and INEA");

endmodule

[rtl/lance_csr_ctl.sv]
// ----------------------------------------------------------------------------
// lance_csr_ctl
// CSR0 control: start, stop, init and transmit demand handling on a CSR0
// write, status set and clear requests, and the interrupt summary.
// ----------------------------------------------------------------------------
module lance_csr_ctl (
    input  lance_csr_pkg::action_t              action,
    input  logic [lance_csr_pkg::DATA_W-1:0]    write_data,
    input  logic [15:0]                         csr0,
    input  logic [lance_csr_pkg::MODE_W-1:0]    mode,
    input  logic                                init_flag,
    output lance_csr_pkg::csr0_upd_t            upd
);

    // Next CSR0 value and side effects for the current request.
    always_comb
    begin
        logic [15:0] c;
        logic        fl;
        c   = csr0;
        fl  = init_flag;
        upd = '0;
        case (action)
            lance_csr_pkg::ACT_SET:
            begin
                c = csr0 | write_data;
            end
            lance_csr_pkg::ACT_CLEAR:
            begin
                c = csr0 & ~write_data;
            end
            lance_csr_pkg::ACT_WRITE:
            begin
                // Enable follows the data, commands set, status bits clear on one.
                c = (csr0 & ~lance_csr_pkg::M_INEA) | (write_data & lance_csr_pkg::M_INEA);
                c = c | (write_data & lance_csr_pkg::M_CMD);
                c = c & ~(write_data & lance_csr_pkg::M_W1C);
                c[lance_csr_pkg::BIT_ERR] = 1'b0;

                if (c[lance_csr_pkg::BIT_STOP] && !csr0[lance_csr_pkg::BIT_STOP])
                begin
                    // Stop resets everything but the stop bit.
                    c              = lance_csr_pkg::M_STOP;
                    upd.csr3_clear = 1'b1;
                end
                else if (c[lance_csr_pkg::BIT_STRT] && !csr0[lance_csr_pkg::BIT_STRT] &&
                         (csr0[lance_csr_pkg::BIT_STOP] || csr0[lance_csr_pkg::BIT_INIT]))
                begin
                    // Start, possibly together with a fresh init.
                    c[lance_csr_pkg::BIT_STOP] = 1'b0;
                    if (!mode[lance_csr_pkg::MODE_DTX])
                    begin
                        c[lance_csr_pkg::BIT_TXON] = 1'b1;
                    end
                    if (!mode[lance_csr_pkg::MODE_DRX])
                    begin
                        c[lance_csr_pkg::BIT_RXON] = 1'b1;
                    end
                    if (c[lance_csr_pkg::BIT_INIT] && !csr0[lance_csr_pkg::BIT_INIT])
                    begin
                        upd.init_now               = 1'b1;
                        c[lance_csr_pkg::BIT_IDON] = 1'b1;
                        fl                         = 1'b1;
                    end
                end
                else if (c[lance_csr_pkg::BIT_INIT] && !csr0[lance_csr_pkg::BIT_INIT] &&
                         csr0[lance_csr_pkg::BIT_STOP])
                begin
                    // Init alone clears STOP and leaves the channels off.
                    upd.init_now               = 1'b1;
                    c[lance_csr_pkg::BIT_IDON] = 1'b1;
                    c[lance_csr_pkg::BIT_RXON] = 1'b0;
                    c[lance_csr_pkg::BIT_TXON] = 1'b0;
                    c[lance_csr_pkg::BIT_STOP] = 1'b0;
                    fl                         = 1'b1;
                    upd.csr3_clear             = 1'b1;
                end

                // Transmit demand is honored only once initialized; it never stays set.
                if (c[lance_csr_pkg::BIT_TDMD])
                begin
                    if (fl)
                    begin
                        if (!c[lance_csr_pkg::BIT_TXON])
                        begin
                            c[lance_csr_pkg::BIT_STOP] = 1'b0;
                            if (!mode[lance_csr_pkg::MODE_DTX])
                            begin
                                c[lance_csr_pkg::BIT_TXON] = 1'b1;
                            end
                            if (!mode[lance_csr_pkg::MODE_DRX])
                            begin
                                c[lance_csr_pkg::BIT_RXON] = 1'b1;
                            end
                        end
                        upd.tx_demand = 1'b1;
                    end
                    c[lance_csr_pkg::BIT_TDMD] = 1'b0;
                end
            end
            default:
            begin
                c = csr0;
            end
        endcase

        // Interrupt summary.
        c[lance_csr_pkg::BIT_INTR] = |(c & lance_csr_pkg::M_SRC);
        upd.irq       = c[lance_csr_pkg::BIT_INTR] & c[lance_csr_pkg::BIT_INEA];
        upd.csr0      = c;
        upd.init_flag = fl;
    end

endmodule

[rtl/lance_csr_store.sv]
// ----------------------------------------------------------------------------
// lance_csr_store
// General register store: one write port and one registered read port, with
// a valid bit per entry so that unwritten entries read as their reset value.
// ----------------------------------------------------------------------------
module lance_csr_store #(
    parameter int REG_COUNT = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [$clog2(REG_COUNT)-1:0]     wa,
    input  logic [lance_csr_pkg::DATA_W-1:0] wd,
    input  logic [$clog2(REG_COUNT)-1:0]     ra,
    output logic [lance_csr_pkg::DATA_W-1:0] rd
);

    localparam int IDX_W = $clog2(REG_COUNT);

    logic [lance_csr_pkg::DATA_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]             valid_reg;
    logic [lance_csr_pkg::DATA_W-1:0] rd_data_reg;
    logic [lance_csr_pkg::DATA_W-1:0] rd_init_reg;
    logic                             rd_valid_reg;
    logic                             fwd;

    // A write to the entry being read is passed straight to the read register.
    assign fwd = we && (wa == ra);

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // Registered read with write forwarding.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= fwd ? wd : mem[ra];
        rd_init_reg <= (ra == IDX_W'(lance_csr_pkg::IDX_CSR4)) ?
                       lance_csr_pkg::CSR4_RESET : '0;
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wa] <= 1'b1;
            end
            rd_valid_reg <= fwd || valid_reg[ra];
        end
    end

    assign rd = rd_valid_reg ? rd_data_reg : rd_init_reg;

endmodule
